[sv/tfv_pkg.sv]
// Package for the touch flick velocity tracker: constants, register indexes,
// sequencer states and the ring entry type.
// No dependencies; every other file takes names from here by scope.
package tfv_pkg;

	localparam int SampleDepth = 16;
	localparam int PtrW        = $clog2(SampleDepth);
	localparam int CntW        = $clog2(SampleDepth + 1);
	localparam int CoordW      = 24;
	localparam int TimeW       = 32;
	localparam int VelW        = 32;
	localparam int WinW        = 5;
	localparam int MinVelW     = 31;
	localparam int CfgIdxW     = 2;
	localparam int CfgDataW    = 32;
	localparam int DiffW       = CoordW + 1;
	localparam int FracShift   = 8;
	localparam int DividendW   = DiffW + FracShift;
	localparam int DivSteps    = DividendW;
	localparam int DivCntW     = $clog2(DivSteps + 1);
	localparam int ProdW       = 2 * VelW;

	localparam logic [WinW-1:0]    WinLenReset = WinW'(4);
	localparam logic [TimeW-1:0]   MaxDurReset = TimeW'(200);
	localparam logic [MinVelW-1:0] MinVelReset = '0;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WINDOW_LEN   = 2'd0,
		REG_MAX_DURATION = 2'd1,
		REG_MIN_VELOCITY = 2'd2
	} tfv_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIVX,
		ST_DIVY,
		ST_MULX,
		ST_MULY,
		ST_MULT,
		ST_CMP,
		ST_FIN
	} tfv_state_t;

	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [TimeW-1:0]  t;
	} tfv_sample_t;

endpackage

[sv/tfv_div.sv]
// Restoring divider that retires one quotient bit per cycle.
// Depends on tfv_pkg for operand widths and the step count.
module tfv_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tfv_pkg::DividendW-1:0]    dividend,
	input  logic [tfv_pkg::TimeW-1:0]        divisor,
	output logic                             done,
	output logic [tfv_pkg::DividendW-1:0]    quotient
);

	logic                          run_q;
	logic                          done_q;
	logic [tfv_pkg::DivCntW-1:0]   cnt_q;
	logic [tfv_pkg::TimeW-1:0]     rem_q;
	logic [tfv_pkg::TimeW-1:0]     dsr_q;
	logic [tfv_pkg::DividendW-1:0] quo_q;
	logic [tfv_pkg::TimeW:0]       trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[tfv_pkg::DividendW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + tfv_pkg::DivCntW'(1);
				if (cnt_q == tfv_pkg::DivCntW'(tfv_pkg::DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= tfv_pkg::TimeW'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[tfv_pkg::TimeW-1:0];
			end
			quo_q <= {quo_q[tfv_pkg::DividendW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/touch_flick_velocity_tracker_core.sv]
// Top level of the touch flick velocity tracker: sample ring, sequencer,
// shared multiplier and the request channels. Uses tfv_pkg and tfv_div.
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    pos_x, pos_y, time_ms
// out      source     out_valid/out_ready  velocity_x/y, enough_samples, duration_ok, velocity_ok
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request runs from acceptance to result through a load step, the serial
// divider for each axis, three multiplier steps, a compare and the final step;
// the next request can be taken in the cycle after the result is loaded.
// Without enough samples or with a zero time span both divisions are skipped.
// Reset clears the write pointer and sample count and restores register defaults.
// One result may wait at the output; the next request then waits in its final step.
module touch_flick_velocity_tracker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tfv_pkg::CoordW-1:0]   pos_x,
	input  logic signed [tfv_pkg::CoordW-1:0]   pos_y,
	input  logic [tfv_pkg::TimeW-1:0]           time_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tfv_pkg::VelW-1:0]     velocity_x,
	output logic signed [tfv_pkg::VelW-1:0]     velocity_y,
	output logic                                enough_samples,
	output logic                                duration_ok,
	output logic                                velocity_ok,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tfv_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [tfv_pkg::CfgDataW-1:0]        cfg_data
);

	localparam logic [tfv_pkg::VelW-1:0] MagPosMax = {1'b0, {(tfv_pkg::VelW-1){1'b1}}};
	localparam logic [tfv_pkg::VelW-1:0] MagNegMax = {1'b1, {(tfv_pkg::VelW-1){1'b0}}};

	tfv_pkg::tfv_state_t  state_q, state_d;
	tfv_pkg::tfv_sample_t ring_mem [tfv_pkg::SampleDepth];
	tfv_pkg::tfv_sample_t new_q, rd_q;

	logic [tfv_pkg::WinW-1:0]    win_len_q;
	logic [tfv_pkg::TimeW-1:0]   max_dur_q;
	logic [tfv_pkg::MinVelW-1:0] min_vel_q;
	logic [tfv_pkg::PtrW-1:0]    wp_q;
	logic [tfv_pkg::CntW-1:0]    cnt_q;

	logic                        in_acc;
	logic [tfv_pkg::CntW-1:0]    wl_eff, cnt_next, wp_after, old_idx;
	logic [tfv_pkg::PtrW-1:0]    wp_next;

	logic                        enough_q, dur_ok_q, vel_ok_q;
	logic signed [tfv_pkg::DiffW-1:0] dx, dy, dy_q;
	logic [tfv_pkg::DiffW-1:0]   abs_dx, abs_dy;
	logic [tfv_pkg::TimeW-1:0]   dt;
	logic                        skip_div;

	logic                        div_start, div_done;
	logic [tfv_pkg::DividendW-1:0] div_dividend, div_quot;
	logic [tfv_pkg::TimeW-1:0]   div_divisor;

	logic                        neg_x_q, neg_y_q;
	logic [tfv_pkg::VelW-1:0]    mag_x_q, mag_y_q, mul_a;
	logic [tfv_pkg::ProdW-1:0]   prod_q;
	logic [tfv_pkg::ProdW:0]     acc_q;

	logic                        out_valid_q, out_load;
	logic [tfv_pkg::VelW-1:0]    vel_x_q, vel_y_q;
	logic                        enough_out_q, dur_out_q, vel_out_q;

	function automatic logic [tfv_pkg::VelW-1:0] sat_mag(
		input logic [tfv_pkg::DividendW-1:0] q,
		input logic                          neg
	);
		logic [tfv_pkg::VelW-1:0] r;
		begin
			if (neg) begin
				r = (q > tfv_pkg::DividendW'(MagNegMax)) ? MagNegMax : q[tfv_pkg::VelW-1:0];
			end else begin
				r = (q > tfv_pkg::DividendW'(MagPosMax)) ? MagPosMax : q[tfv_pkg::VelW-1:0];
			end
			return r;
		end
	endfunction

	// Configuration registers; writes are always accepted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= tfv_pkg::WinLenReset;
			max_dur_q <= tfv_pkg::MaxDurReset;
			min_vel_q <= tfv_pkg::MinVelReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tfv_pkg::REG_WINDOW_LEN:   win_len_q <= cfg_data[tfv_pkg::WinW-1:0];
				tfv_pkg::REG_MAX_DURATION: max_dur_q <= cfg_data[tfv_pkg::TimeW-1:0];
				tfv_pkg::REG_MIN_VELOCITY: min_vel_q <= cfg_data[tfv_pkg::MinVelW-1:0];
				default: ;
			endcase
		end
	end

	// Ring addressing: the oldest sample of the window lies wl_eff places back from the next write position.
	assign in_acc   = in_valid && in_ready;
	assign wl_eff   = (win_len_q < tfv_pkg::WinW'(2)) ? tfv_pkg::CntW'(2) :
	                  (tfv_pkg::CntW'(win_len_q) > tfv_pkg::CntW'(tfv_pkg::SampleDepth)) ?
	                  tfv_pkg::CntW'(tfv_pkg::SampleDepth) : tfv_pkg::CntW'(win_len_q);
	assign cnt_next = (cnt_q < tfv_pkg::CntW'(tfv_pkg::SampleDepth)) ?
	                  cnt_q + tfv_pkg::CntW'(1) : cnt_q;
	assign wp_next  = (wp_q == tfv_pkg::PtrW'(tfv_pkg::SampleDepth - 1)) ?
	                  '0 : wp_q + tfv_pkg::PtrW'(1);
	assign wp_after = tfv_pkg::CntW'(wp_next);
	assign old_idx  = (wp_after >= wl_eff) ? wp_after - wl_eff :
	                  wp_after + tfv_pkg::CntW'(tfv_pkg::SampleDepth) - wl_eff;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[wp_q] <= '{x: pos_x, y: pos_y, t: time_ms};
			rd_q           <= ring_mem[old_idx[tfv_pkg::PtrW-1:0]];
			new_q          <= '{x: pos_x, y: pos_y, t: time_ms};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			enough_q <= 1'b0;
		end else if (in_acc) begin
			wp_q     <= wp_next;
			cnt_q    <= cnt_next;
			enough_q <= cnt_next >= wl_eff;
		end
	end

	// Differences between the newest sample and the oldest one of the window.
	assign dt       = new_q.t - rd_q.t;
	assign dx       = tfv_pkg::DiffW'($signed(new_q.x)) - tfv_pkg::DiffW'($signed(rd_q.x));
	assign dy       = tfv_pkg::DiffW'($signed(new_q.y)) - tfv_pkg::DiffW'($signed(rd_q.y));
	assign abs_dx   = dx[tfv_pkg::DiffW-1] ? tfv_pkg::DiffW'(-dx) : tfv_pkg::DiffW'(dx);
	assign abs_dy   = dy_q[tfv_pkg::DiffW-1] ? tfv_pkg::DiffW'(-dy_q) : tfv_pkg::DiffW'(dy_q);
	assign skip_div = !enough_q || (dt == '0);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfv_pkg::ST_IDLE: if (in_acc) state_d = tfv_pkg::ST_LOAD;
			tfv_pkg::ST_LOAD: state_d = skip_div ? tfv_pkg::ST_MULX : tfv_pkg::ST_DIVX;
			tfv_pkg::ST_DIVX: if (div_done) state_d = tfv_pkg::ST_DIVY;
			tfv_pkg::ST_DIVY: if (div_done) state_d = tfv_pkg::ST_MULX;
			tfv_pkg::ST_MULX: state_d = tfv_pkg::ST_MULY;
			tfv_pkg::ST_MULY: state_d = tfv_pkg::ST_MULT;
			tfv_pkg::ST_MULT: state_d = tfv_pkg::ST_CMP;
			tfv_pkg::ST_CMP:  state_d = tfv_pkg::ST_FIN;
			tfv_pkg::ST_FIN:  if (out_load) state_d = tfv_pkg::ST_IDLE;
			default:          state_d = tfv_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = {abs_dx, {tfv_pkg::FracShift{1'b0}}};
		mul_a        = mag_x_q;
		out_load     = 1'b0;
		unique case (state_q)
			tfv_pkg::ST_IDLE: in_ready = 1'b1;
			tfv_pkg::ST_LOAD: div_start = !skip_div;
			tfv_pkg::ST_DIVX: begin
				div_start    = div_done;
				div_dividend = {abs_dy, {tfv_pkg::FracShift{1'b0}}};
			end
			tfv_pkg::ST_MULY: mul_a = mag_y_q;
			tfv_pkg::ST_MULT: mul_a = tfv_pkg::VelW'(min_vel_q);
			tfv_pkg::ST_FIN:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign div_divisor = dt;

	tfv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			tfv_pkg::ST_LOAD: begin
				dy_q     <= dy;
				neg_x_q  <= dx[tfv_pkg::DiffW-1];
				neg_y_q  <= dy[tfv_pkg::DiffW-1];
				dur_ok_q <= enough_q && (dt <= max_dur_q);
				mag_x_q  <= '0;
				mag_y_q  <= '0;
			end
			tfv_pkg::ST_DIVX: if (div_done) mag_x_q <= sat_mag(div_quot, neg_x_q);
			tfv_pkg::ST_DIVY: if (div_done) mag_y_q <= sat_mag(div_quot, neg_y_q);
			tfv_pkg::ST_MULX: prod_q <= mul_a * mul_a;
			tfv_pkg::ST_MULY: begin
				acc_q  <= {1'b0, prod_q};
				prod_q <= mul_a * mul_a;
			end
			tfv_pkg::ST_MULT: begin
				acc_q  <= acc_q + {1'b0, prod_q};
				prod_q <= mul_a * mul_a;
			end
			tfv_pkg::ST_CMP: vel_ok_q <= enough_q && (acc_q >= {1'b0, prod_q});
			default: ;
		endcase
	end

	// Output register; the result waits here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vel_x_q      <= neg_x_q ? tfv_pkg::VelW'(-mag_x_q) : mag_x_q;
			vel_y_q      <= neg_y_q ? tfv_pkg::VelW'(-mag_y_q) : mag_y_q;
			enough_out_q <= enough_q;
			dur_out_q    <= dur_ok_q;
			vel_out_q    <= vel_ok_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign velocity_x     = $signed(vel_x_q);
	assign velocity_y     = $signed(vel_y_q);
	assign enough_samples = enough_out_q;
	assign duration_ok    = dur_out_q;
	assign velocity_ok    = vel_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tfv_pkg::CntW'(tfv_pkg::SampleDepth))
		else $error("Sample count has passed the ring depth.");

	a_short_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (enough_samples || (velocity_x == '0 && velocity_y == '0 &&
		!duration_ok && !velocity_ok)))
		else $error("A result without enough samples is not all zero.");

	a_flags_need_samples: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (duration_ok || velocity_ok) |-> enough_samples)
		else $error("A check passed without enough samples.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !div_done)
		else $error("A request was taken while the previous one was in progress.");

	a_load_only_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && $past(state_q == tfv_pkg::ST_FIN))
		else $error("A result was loaded outside the final step.");

endmodule
